/* rtl/segmented_free_list_slot_allocator_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the slot allocator
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_FREE_LIST_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define SEGMENTED_FREE_LIST_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and off during reset.
`define SFLA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot allocator check failed");
// Next-cycle implication, sampled on clk and off during reset.
`define SFLA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot allocator check failed");
`else
`define SFLA_ASSERT_IMP(name, ante, cons)
`define SFLA_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* rtl/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// Slot allocator package
// Opcodes, status codes, register indexes, slot states, link fields and sequencer states.
// ----------------------------------------------------------------------------
package sfla_pkg;

  typedef enum logic [1:0] {
    OP_ROUND   = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_NOT_LIVE = 2'd2,
    ST_CAP_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_MIN_FREE  = 2'd0,
    CFG_MAX_FREE  = 2'd1,
    CFG_SEG_SLOTS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SS_FREE    = 2'd0,
    SS_LIVE    = 2'd1,
    SS_RETIRED = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    FLD_FNEXT = 2'd0,
    FLD_FPREV = 2'd1,
    FLD_LNEXT = 2'd2,
    FLD_LPREV = 2'd3
  } link_field_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_WR,
    S_X_WR,
    S_Q_CK,
    S_G_CHK,
    S_G_PUSH,
    S_R_TOP,
    S_R_SEG,
    S_R_SCAN_RD,
    S_R_SCAN_CK,
    S_R_MIN,
    S_R_UN_RD,
    S_R_UN_WR,
    S_R_SEG_DONE,
    S_FIX_RD,
    S_FIX_WR,
    S_FINISH
  } ctrl_state_t;

endpackage

/* rtl/sfla_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sfla_ctrl.sv */
// ----------------------------------------------------------------------------
// Slot allocator sequencer
// Runs each operation as read-modify-write steps on the slot and segment RAMs.
// ----------------------------------------------------------------------------
module sfla_ctrl
  import sfla_pkg::*;
#(
  parameter int SLOT_CAPACITY    = 1024,
  parameter int SEGMENT_CAPACITY = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            opcode,
  input  logic [$clog2(SLOT_CAPACITY)-1:0]      slot_index,
  input  logic                                  from_head,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [$clog2(SLOT_CAPACITY)-1:0]      result_slot,
  output logic                                  result_valid,
  output logic [$clog2(SLOT_CAPACITY):0]        free_total,
  output logic [$clog2(SLOT_CAPACITY):0]        live_total,
  input  logic [$clog2(SLOT_CAPACITY):0]        free_floor,
  input  logic [$clog2(SLOT_CAPACITY):0]        free_ceil,
  input  logic [$clog2(SLOT_CAPACITY):0]        seg_slots,
  output logic                                  s_we,
  output logic [$clog2(SLOT_CAPACITY)-1:0]      s_waddr,
  output logic [2+4*($clog2(SLOT_CAPACITY)+1)-1:0] s_wdata,
  output logic [$clog2(SLOT_CAPACITY)-1:0]      s_raddr,
  input  logic [2+4*($clog2(SLOT_CAPACITY)+1)-1:0] s_rdata,
  output logic                                  g_we,
  output logic [$clog2(SEGMENT_CAPACITY)-1:0]   g_waddr,
  output logic [2*$clog2(SLOT_CAPACITY)+1:0]    g_wdata,
  output logic [$clog2(SEGMENT_CAPACITY)-1:0]   g_raddr,
  input  logic [2*$clog2(SLOT_CAPACITY)+1:0]    g_rdata
);

  localparam int SW   = $clog2(SLOT_CAPACITY);
  localparam int LW   = SW + 1;
  localparam int WW   = 2 + 4 * LW;
  localparam int SEGW = $clog2(SEGMENT_CAPACITY);
  localparam int GW   = SEGW + 1;
  localparam int GWW  = 1 + LW + SW;
  localparam logic [LW-1:0] LNIL   = {LW{1'b1}};
  localparam logic [GW-1:0] GNIL   = {GW{1'b1}};
  localparam logic [LW-1:0] CAP_LW = LW'(SLOT_CAPACITY);
  localparam logic [GW-1:0] SEG_GW = GW'(SEGMENT_CAPACITY);

  function automatic logic [WW-1:0] put_field(input logic [WW-1:0] w,
                                              input link_field_t f,
                                              input logic [LW-1:0] v);
    logic [WW-1:0] r;
    r = w;
    case (f)
      FLD_FNEXT: r[3*LW +: LW] = v;
      FLD_FPREV: r[2*LW +: LW] = v;
      FLD_LNEXT: r[LW +: LW]   = v;
      FLD_LPREV: r[0 +: LW]    = v;
      default:   r = w;
    endcase
    return r;
  endfunction

  ctrl_state_t state, state_next, ret_st, ret_st_next;
  logic [LW-1:0] fhead, fhead_next, lhead, lhead_next, ltail, ltail_next;
  logic [LW-1:0] free_cnt, free_cnt_next, live_cnt, live_cnt_next;
  logic [LW-1:0] slots_made, slots_made_next;
  logic [GW-1:0] segs_made, segs_made_next, last_seg, last_seg_next;
  logic [SW-1:0] idx_q, idx_q_next, base_q, base_q_next, res_q, res_q_next;
  logic [LW-1:0] len_q, len_q_next, cnt, cnt_next;
  status_t       st_q, st_q_next;
  logic          resv_q, resv_q_next;
  logic [2:0]    fix_pend, fix_pend_next;
  logic [SW-1:0] fix_addr [3];
  logic [SW-1:0] fix_addr_next [3];
  link_field_t   fix_sel [3];
  link_field_t   fix_sel_next [3];
  logic [LW-1:0] fix_val [3];
  logic [LW-1:0] fix_val_next [3];
  logic [1:0]    fix_j;
  logic          out_valid_next, out_rvalid, out_rvalid_next;
  logic [1:0]    out_status, out_status_next;
  logic [SW-1:0] out_slot, out_slot_next;
  logic [LW-1:0] out_free, out_free_next, out_live, out_live_next;

  slot_state_t   rd_state;
  logic [LW-1:0] rd_fnext, rd_fprev, rd_lnext, rd_lprev;
  logic [SW-1:0] cur_slot;
  logic [LW-1:0] cnt_inc;
  logic          last_i;
  logic [GW-1:0] seg_back;

  assign rd_state = slot_state_t'(s_rdata[WW-1 -: 2]);
  assign rd_fnext = s_rdata[3*LW +: LW];
  assign rd_fprev = s_rdata[2*LW +: LW];
  assign rd_lnext = s_rdata[LW +: LW];
  assign rd_lprev = s_rdata[0 +: LW];
  assign cur_slot = SW'(LW'(base_q) + cnt);
  assign cnt_inc  = cnt + LW'(1);
  assign last_i   = (cnt_inc == len_q);
  assign seg_back = (last_seg == '0) ? GNIL : last_seg - GW'(1);
  assign fix_j    = fix_pend[0] ? 2'd0 : (fix_pend[1] ? 2'd1 : 2'd2);

  assign in_ready     = (state == S_IDLE);
  assign status       = out_status;
  assign result_slot  = out_slot;
  assign result_valid = out_rvalid;
  assign free_total   = out_free;
  assign live_total   = out_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_st     <= S_IDLE;
      fhead      <= LNIL;
      lhead      <= LNIL;
      ltail      <= LNIL;
      free_cnt   <= '0;
      live_cnt   <= '0;
      slots_made <= '0;
      segs_made  <= '0;
      last_seg   <= GNIL;
      fix_pend   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ret_st     <= ret_st_next;
      fhead      <= fhead_next;
      lhead      <= lhead_next;
      ltail      <= ltail_next;
      free_cnt   <= free_cnt_next;
      live_cnt   <= live_cnt_next;
      slots_made <= slots_made_next;
      segs_made  <= segs_made_next;
      last_seg   <= last_seg_next;
      fix_pend   <= fix_pend_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx_q      <= idx_q_next;
    base_q     <= base_q_next;
    len_q      <= len_q_next;
    cnt        <= cnt_next;
    st_q       <= st_q_next;
    res_q      <= res_q_next;
    resv_q     <= resv_q_next;
    fix_addr   <= fix_addr_next;
    fix_sel    <= fix_sel_next;
    fix_val    <= fix_val_next;
    out_status <= out_status_next;
    out_slot   <= out_slot_next;
    out_rvalid <= out_rvalid_next;
    out_free   <= out_free_next;
    out_live   <= out_live_next;
  end

  always_comb begin
    state_next      = state;
    ret_st_next     = ret_st;
    fhead_next      = fhead;
    lhead_next      = lhead;
    ltail_next      = ltail;
    free_cnt_next   = free_cnt;
    live_cnt_next   = live_cnt;
    slots_made_next = slots_made;
    segs_made_next  = segs_made;
    last_seg_next   = last_seg;
    idx_q_next      = idx_q;
    base_q_next     = base_q;
    len_q_next      = len_q;
    cnt_next        = cnt;
    st_q_next       = st_q;
    res_q_next      = res_q;
    resv_q_next     = resv_q;
    fix_pend_next   = fix_pend;
    fix_addr_next   = fix_addr;
    fix_sel_next    = fix_sel;
    fix_val_next    = fix_val;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_slot_next   = out_slot;
    out_rvalid_next = out_rvalid;
    out_free_next   = out_free;
    out_live_next   = out_live;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    g_we    = 1'b0;
    g_waddr = '0;
    g_wdata = '0;
    g_raddr = '0;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          st_q_next   = ST_OK;
          res_q_next  = '0;
          resv_q_next = 1'b0;
          idx_q_next  = slot_index;
          case (opcode_t'(opcode))
            OP_ROUND: state_next = S_G_CHK;
            OP_ALLOC: begin
              if (fhead == LNIL) begin
                st_q_next  = ST_NO_FREE;
                state_next = S_FINISH;
              end else begin
                s_raddr    = fhead[SW-1:0];
                state_next = S_A_WR;
              end
            end
            OP_RELEASE: begin
              if (LW'(slot_index) < slots_made) begin
                s_raddr    = slot_index;
                state_next = S_X_WR;
              end else begin
                st_q_next  = ST_NOT_LIVE;
                state_next = S_FINISH;
              end
            end
            OP_QUERY: begin
              if (from_head) begin
                res_q_next  = (lhead == LNIL) ? '0 : lhead[SW-1:0];
                resv_q_next = (lhead != LNIL);
                state_next  = S_FINISH;
              end else if (LW'(slot_index) < slots_made) begin
                s_raddr    = slot_index;
                state_next = S_Q_CK;
              end else begin
                st_q_next  = ST_NOT_LIVE;
                state_next = S_FINISH;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end

      // Pop the free head, append it at the live tail.
      S_A_WR: begin
        s_we    = 1'b1;
        s_waddr = fhead[SW-1:0];
        s_wdata = {SS_LIVE, LNIL, LNIL, LNIL, ltail};
        fhead_next = rd_fnext;
        if (rd_fnext != LNIL) begin
          fix_pend_next[0] = 1'b1;
          fix_addr_next[0] = rd_fnext[SW-1:0];
          fix_sel_next[0]  = FLD_FPREV;
          fix_val_next[0]  = LNIL;
        end
        if (ltail != LNIL) begin
          fix_pend_next[1] = 1'b1;
          fix_addr_next[1] = ltail[SW-1:0];
          fix_sel_next[1]  = FLD_LNEXT;
          fix_val_next[1]  = fhead;
        end else begin
          lhead_next = fhead;
        end
        ltail_next    = fhead;
        free_cnt_next = free_cnt - LW'(1);
        live_cnt_next = live_cnt + LW'(1);
        res_q_next    = fhead[SW-1:0];
        resv_q_next   = 1'b1;
        ret_st_next   = S_FINISH;
        state_next    = S_FIX_RD;
      end

      // Unlink from the live list and push on the free head.
      S_X_WR: begin
        if (rd_state != SS_LIVE) begin
          st_q_next  = ST_NOT_LIVE;
          state_next = S_FINISH;
        end else begin
          s_we    = 1'b1;
          s_waddr = idx_q;
          s_wdata = {SS_FREE, fhead, LNIL, LNIL, LNIL};
          if (rd_lprev != LNIL) begin
            fix_pend_next[0] = 1'b1;
            fix_addr_next[0] = rd_lprev[SW-1:0];
            fix_sel_next[0]  = FLD_LNEXT;
            fix_val_next[0]  = rd_lnext;
          end else begin
            lhead_next = rd_lnext;
          end
          if (rd_lnext != LNIL) begin
            fix_pend_next[1] = 1'b1;
            fix_addr_next[1] = rd_lnext[SW-1:0];
            fix_sel_next[1]  = FLD_LPREV;
            fix_val_next[1]  = rd_lprev;
          end else begin
            ltail_next = rd_lprev;
          end
          if (fhead != LNIL) begin
            fix_pend_next[2] = 1'b1;
            fix_addr_next[2] = fhead[SW-1:0];
            fix_sel_next[2]  = FLD_FPREV;
            fix_val_next[2]  = LW'(idx_q);
          end
          fhead_next    = LW'(idx_q);
          live_cnt_next = live_cnt - LW'(1);
          free_cnt_next = free_cnt + LW'(1);
          ret_st_next   = S_FINISH;
          state_next    = S_FIX_RD;
        end
      end

      S_Q_CK: begin
        if (rd_state != SS_LIVE) begin
          st_q_next = ST_NOT_LIVE;
        end else if (rd_lnext != LNIL) begin
          res_q_next  = rd_lnext[SW-1:0];
          resv_q_next = 1'b1;
        end
        state_next = S_FINISH;
      end

      // Add one segment if free slots are short and a segment still fits.
      S_G_CHK: begin
        if (free_cnt < free_floor) begin
          if (seg_slots == '0 || segs_made >= SEG_GW ||
              seg_slots > (CAP_LW - slots_made)) begin
            st_q_next  = ST_CAP_FULL;
            state_next = S_R_TOP;
          end else begin
            g_we            = 1'b1;
            g_waddr         = segs_made[SEGW-1:0];
            g_wdata         = {1'b1, seg_slots, slots_made[SW-1:0]};
            last_seg_next   = segs_made;
            segs_made_next  = segs_made + GW'(1);
            base_q_next     = slots_made[SW-1:0];
            len_q_next      = seg_slots;
            cnt_next        = '0;
            slots_made_next = slots_made + seg_slots;
            state_next      = S_G_PUSH;
          end
        end else begin
          state_next = S_R_TOP;
        end
      end

      S_G_PUSH: begin
        s_we    = 1'b1;
        s_waddr = cur_slot;
        s_wdata = {SS_FREE, fhead, LNIL, LNIL, LNIL};
        if (fhead != LNIL) begin
          fix_pend_next[0] = 1'b1;
          fix_addr_next[0] = fhead[SW-1:0];
          fix_sel_next[0]  = FLD_FPREV;
          fix_val_next[0]  = LW'(cur_slot);
        end
        fhead_next    = LW'(cur_slot);
        free_cnt_next = free_cnt + LW'(1);
        cnt_next      = cnt_inc;
        ret_st_next   = last_i ? S_G_CHK : S_G_PUSH;
        state_next    = S_FIX_RD;
      end

      S_R_TOP: begin
        if (free_cnt > free_ceil && last_seg != GNIL) begin
          g_raddr    = last_seg[SEGW-1:0];
          state_next = S_R_SEG;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_R_SEG: begin
        if (!g_rdata[GWW-1]) begin
          last_seg_next = seg_back;
          state_next    = S_R_TOP;
        end else begin
          base_q_next = g_rdata[SW-1:0];
          len_q_next  = g_rdata[SW +: LW];
          cnt_next    = '0;
          state_next  = S_R_SCAN_RD;
        end
      end

      S_R_SCAN_RD: begin
        s_raddr    = cur_slot;
        state_next = S_R_SCAN_CK;
      end

      // Every slot of the tail segment has to be on the free list.
      S_R_SCAN_CK: begin
        if (rd_state != SS_FREE) begin
          state_next = S_FINISH;
        end else if (last_i) begin
          cnt_next   = '0;
          state_next = S_R_MIN;
        end else begin
          cnt_next   = cnt_inc;
          state_next = S_R_SCAN_RD;
        end
      end

      S_R_MIN: begin
        if ((free_cnt - len_q) < free_floor) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_R_UN_RD;
        end
      end

      S_R_UN_RD: begin
        s_raddr    = cur_slot;
        state_next = S_R_UN_WR;
      end

      S_R_UN_WR: begin
        s_we    = 1'b1;
        s_waddr = cur_slot;
        s_wdata = {SS_RETIRED, LNIL, LNIL, rd_lnext, rd_lprev};
        if (rd_fprev != LNIL) begin
          fix_pend_next[0] = 1'b1;
          fix_addr_next[0] = rd_fprev[SW-1:0];
          fix_sel_next[0]  = FLD_FNEXT;
          fix_val_next[0]  = rd_fnext;
        end else begin
          fhead_next = rd_fnext;
        end
        if (rd_fnext != LNIL) begin
          fix_pend_next[1] = 1'b1;
          fix_addr_next[1] = rd_fnext[SW-1:0];
          fix_sel_next[1]  = FLD_FPREV;
          fix_val_next[1]  = rd_fprev;
        end
        free_cnt_next = free_cnt - LW'(1);
        cnt_next      = cnt_inc;
        ret_st_next   = last_i ? S_R_SEG_DONE : S_R_UN_RD;
        state_next    = S_FIX_RD;
      end

      S_R_SEG_DONE: begin
        g_we          = 1'b1;
        g_waddr       = last_seg[SEGW-1:0];
        g_wdata       = {1'b0, len_q, base_q};
        last_seg_next = seg_back;
        state_next    = S_R_TOP;
      end

      // Neighbor link updates, one read-modify-write per pending entry.
      S_FIX_RD: begin
        if (fix_pend == '0) begin
          state_next = ret_st;
        end else begin
          s_raddr    = fix_addr[fix_j];
          state_next = S_FIX_WR;
        end
      end

      S_FIX_WR: begin
        s_we    = 1'b1;
        s_waddr = fix_addr[fix_j];
        s_wdata = put_field(s_rdata, fix_sel[fix_j], fix_val[fix_j]);
        fix_pend_next[fix_j] = 1'b0;
        state_next = S_FIX_RD;
      end

      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          out_status_next = st_q;
          out_slot_next   = res_q;
          out_rvalid_next = resv_q;
          out_free_next   = free_cnt;
          out_live_next   = live_cnt;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/segmented_free_list_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Segmented free-list slot allocator
// Hands out slots from a LIFO free list, tracks live slots in allocation
// order, and grows or retires slot segments of configurable size on round entry.
// ----------------------------------------------------------------------------
// Usage: one transaction on the input channel (in_valid/in_ready) carries an
// opcode, a slot index and a from_head flag; each yields exactly one result
// transaction on the output channel (out_valid/out_ready). The block works on
// one transaction at a time; in_ready is high only while the sequencer idles.
// The slot links live in a RAM with a registered read and every list edit is a
// read-modify-write through its single read and single write port.
// The result sits in an output register, so the next transaction is accepted
// as soon as it has been written there; a stalled receiver only holds the
// sequencer in its final state until the register frees up.
// Reset clears the list heads, counters and segment pointers; no RAM clearing
// pass is needed, so the block accepts a transaction in the first cycle after
// reset. Configuration writes are taken at any edge with cfg_we high.
// ----------------------------------------------------------------------------
module segmented_free_list_slot_allocator_unit
  import sfla_pkg::*;
#(
  parameter int SLOT_CAPACITY    = 1024,
  parameter int SEGMENT_CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [$clog2(SLOT_CAPACITY):0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic [$clog2(SLOT_CAPACITY)-1:0] slot_index,
  input  logic                             from_head,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [$clog2(SLOT_CAPACITY)-1:0] result_slot,
  output logic                             result_valid,
  output logic [$clog2(SLOT_CAPACITY):0]   free_total,
  output logic [$clog2(SLOT_CAPACITY):0]   live_total
);

`include "segmented_free_list_slot_allocator_unit_assert.svh"

  localparam int SW   = $clog2(SLOT_CAPACITY);
  localparam int LW   = SW + 1;
  localparam int WW   = 2 + 4 * LW;
  localparam int SEGW = $clog2(SEGMENT_CAPACITY);
  localparam int GWW  = 1 + LW + SW;
  localparam logic [LW:0] CAP_SUM = (LW + 1)'(SLOT_CAPACITY);

  logic [LW-1:0] free_floor, free_ceil, seg_slots;
  logic          s_we, g_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [WW-1:0] s_wdata, s_rdata;
  logic [SEGW-1:0] g_waddr, g_raddr;
  logic [GWW-1:0]  g_wdata, g_rdata;
  logic [LW:0]     total_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_floor <= '0;
      free_ceil  <= LW'(SLOT_CAPACITY);
      seg_slots  <= LW'(16);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIN_FREE:  free_floor <= cfg_data;
        CFG_MAX_FREE:  free_ceil  <= cfg_data;
        CFG_SEG_SLOTS: seg_slots  <= cfg_data;
        default: ;
      endcase
    end
  end

  sfla_ram #(.WIDTH(WW), .DEPTH(SLOT_CAPACITY)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sfla_ram #(.WIDTH(GWW), .DEPTH(SEGMENT_CAPACITY)) u_seg_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  sfla_ctrl #(
    .SLOT_CAPACITY    (SLOT_CAPACITY),
    .SEGMENT_CAPACITY (SEGMENT_CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .slot_index   (slot_index),
    .from_head    (from_head),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_slot  (result_slot),
    .result_valid (result_valid),
    .free_total   (free_total),
    .live_total   (live_total),
    .free_floor   (free_floor),
    .free_ceil    (free_ceil),
    .seg_slots    (seg_slots),
    .s_we         (s_we),
    .s_waddr      (s_waddr),
    .s_wdata      (s_wdata),
    .s_raddr      (s_raddr),
    .s_rdata      (s_rdata),
    .g_we         (g_we),
    .g_waddr      (g_waddr),
    .g_wdata      (g_wdata),
    .g_raddr      (g_raddr),
    .g_rdata      (g_rdata)
  );

  assign total_sum = (LW + 1)'(free_total) + (LW + 1)'(live_total);

  // Only one transaction is in flight inside the sequencer.
  `SFLA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `SFLA_ASSERT_IMP(a_slot_zero_if_none, out_valid && !result_valid, result_slot == '0)
  `SFLA_ASSERT_IMP(a_totals_fit, out_valid, total_sum <= CAP_SUM)
  `SFLA_ASSERT_IMP(a_slot_means_ok, out_valid && result_valid, status == ST_OK)

endmodule
